// File: sv/signed_int_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// property must hold at every clock edge out of reset
`define SITDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SITDA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: sv/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Widths, character codes, control/status types and the BCD adjust function.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS = 32;
  // decimal digits needed for any magnitude of VALUE_BITS bits (log10(2) ~ 0.30103)
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(57);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CHAR_W-1:0]            char_t;

  typedef struct packed {
    logic load;        // capture a new value
    logic step;        // one shift-add-3 step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register
  } sitda_cmd_t;

  typedef struct packed {
    logic conv_last;   // this step is the final conversion step
    logic top_zero;    // top digit is zero
    logic one_left;    // only one digit remains
    logic negative;    // captured value is negative
    logic out_free;    // output register can take a character this cycle
  } sitda_stat_t;

  // add 3 to every digit of 5 or more before the next left shift
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

// File: sv/sitda_in_if.sv
// ----------------------------------------------------------------------------
// sitda_in_if
// Input channel: one signed integer per transfer.
// ----------------------------------------------------------------------------
interface sitda_in_if
  import sitda_pkg::*;
;
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// File: sv/sitda_out_if.sv
// ----------------------------------------------------------------------------
// sitda_out_if
// Output channel: one ASCII character per transfer, flagged on the last one.
// ----------------------------------------------------------------------------
interface sitda_out_if
  import sitda_pkg::*;
;
  logic  valid;
  logic  ready;
  char_t character;
  logic  last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// File: sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed two's-complement integer into its decimal ASCII text,
// one character per output transfer, most significant digit first, with a
// leading '-' for negative values, no leading zeros, and the final character
// flagged by last. One value is in work at a time: after the input transfer
// the magnitude goes through VALUE_BITS shift-add-3 steps of a serial
// binary-to-BCD converter, then a skip step per suppressed leading
// zero, a step that starts emission, and one emission per character through a
// single output register; the sign and the digits wait for that register
// while the output stalls. The conversion loop sets most of the time from
// one input transfer to the next. The next value is taken while the last
// character of the previous one still waits in the output register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input logic         clk,
  input logic         rst,
  sitda_in_if.sink    din,
  sitda_out_if.source dout
);

  sitda_cmd_t  cmd;
  sitda_stat_t stat;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sitda_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (din.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .character (dout.character),
    .last      (dout.last)
  );

  `SITDA_ASSERT(a_busy_after_accept, (din.valid && din.ready) |=> !din.ready, "input accepted while busy")
  `SITDA_NEVER(a_last_is_sign, dout.valid && dout.last && (dout.character == CH_MINUS), "run ends in sign")
  `SITDA_ASSERT(a_char_range, dout.valid |-> ((dout.character == CH_MINUS) || ((dout.character >= CH_ZERO) && (dout.character <= CH_NINE))), "bad character code")
  `SITDA_NEVER(a_emit_overwrite, (cmd.emit_sign || cmd.emit_digit) && dout.valid && !dout.ready, "output overwritten")

endmodule

// File: sv/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: capture, serial binary-to-BCD conversion, leading zero skip,
// sign and digit emission.
// ----------------------------------------------------------------------------
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sitda_stat_t stat,
  output sitda_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.one_left) begin
          cmd.skip = 1'b1;
        end else if (stat.negative) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.one_left) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/sitda_dp.sv
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude shifter, BCD register, digit counters and the
// output character register.
// ----------------------------------------------------------------------------
module sitda_dp
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  value_t      value,
  input  sitda_cmd_t  cmd,
  output sitda_stat_t stat,
  output logic        out_valid,
  input  logic        out_ready,
  output char_t       character,
  output logic        last
);

  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      bit_cnt;
  logic [DIG_W-1:0]      dig_cnt;
  logic                  negative;
  logic [3:0]            top_digit;

  assign value_u   = $unsigned(value);
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign bcd_adj   = bcd_adjust(bcd);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value_u[VALUE_BITS-1];
      mag      <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
      bcd      <= '0;
      bit_cnt  <= '0;
      dig_cnt  <= DIG_W'(NUM_DIGITS);
    end else if (cmd.step) begin
      mag     <= {mag[VALUE_BITS-2:0], 1'b0};
      bcd     <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
      bit_cnt <= bit_cnt + CNT_W'(1);
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - DIG_W'(1);
    end
  end

  // output register, freed by a transfer on the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CH_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= CH_ZERO + CHAR_W'(top_digit);
      last      <= (dig_cnt == DIG_W'(1));
    end
  end

  always_comb begin
    stat.conv_last = (bit_cnt == CNT_W'(VALUE_BITS - 1));
    stat.top_zero  = (top_digit == 4'd0);
    stat.one_left  = (dig_cnt == DIG_W'(1));
    stat.negative  = negative;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule
